@@ hw/rtl/nrle_pkg.sv @@
// Shared types and constants of the nibble run-length gray image decoder.
// No dependencies; the top level, front end, queue and sequencer import it.
package nrle_pkg;

  localparam logic [7:0] WIDTH_RESET  = 8'd128;
  localparam logic [7:0] HEIGHT_RESET = 8'd64;

  // Configuration register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  // Nibble codes that open a run instead of giving a literal pixel
  localparam logic [3:0] RUN_DARK  = 4'h0;
  localparam logic [3:0] RUN_LIGHT = 4'hF;

  // One compressed byte after classification by the front end
  typedef struct packed {
    logic [7:0] data;
    logic       hi_open;  // high nibble opens a run
    logic       lo_open;  // low nibble opens a run (when read as a color code)
  } byte_entry_t;

  typedef struct packed {
    logic [23:0] color;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        last;
    logic        done;
  } pixel_t;

  function automatic logic is_run_code(input logic [3:0] code);
    return (code == RUN_DARK) || (code == RUN_LIGHT);
  endfunction

  function automatic logic [23:0] gray_to_color(input logic [3:0] gray);
    return {6{gray}};
  endfunction

endpackage

@@ hw/rtl/nrle_byte_if.sv @@
// Handshake channel that carries one compressed byte per transfer.
// No dependencies.
interface nrle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source(output valid, output stream_byte, input ready);
  modport sink(input valid, input stream_byte, output ready);
endinterface

@@ hw/rtl/nrle_pixel_if.sv @@
// Handshake channel that carries one decoded pixel per transfer.
// No dependencies.
interface nrle_pixel_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_color;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic        last_of_byte;
  logic        image_done;

  modport source(output valid, output pixel_color, output pixel_x, output pixel_y,
                 output last_of_byte, output image_done, input ready);
  modport sink(input valid, input pixel_color, input pixel_x, input pixel_y,
               input last_of_byte, input image_done, output ready);
endinterface

@@ hw/rtl/nibble_rle_image_decoder.sv @@
// Top level of the nibble run-length gray image decoder.
// Depends on nrle_pkg, nrle_byte_if, nrle_pixel_if, nrle_front, nrle_queue, nrle_back.
//
// Usage:
//   stream  - input channel, one compressed byte per transfer; the high nibble
//             is decoded first. Codes 1..14 are literal gray pixels, 0 and 15
//             open a run whose length minus one is the next nibble.
//   pixel   - output channel, one pixel per transfer: gray replicated into
//             24-bit color, raster x/y, last_of_byte and image_done flags.
//   cfg_*   - register writes (0: image width, 1: image height), taken in the
//             cycle cfg_we is high; write only while the decoder is idle.
// Throughput: the sequencer emits one pixel per cycle while a byte is queued and
//   the output register is free; each run-opening nibble takes a step of its own
//   that emits no pixel.
// Path: the first pixel of a byte passes the front-end entry register, a queue
//   slot and the output register after the byte's transfer; a sequencer step
//   without output comes first when the high nibble opens a run.
// Reset: clears the decoding position, run state, queue and output, and loads
//   width 128 and height 64. Once the last row fills, bytes are drained and
//   dropped without output until reset or a larger height is written.
// Stall: a stalled receiver holds the output register; the sequencer waits,
//   the queue fills, and only then does stream.ready drop.
module nibble_rle_image_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  nrle_byte_if.sink    stream,
  nrle_pixel_if.source pixel,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_wdata
);
  import nrle_pkg::*;

  logic [7:0]  image_width;
  logic [7:0]  image_height;

  logic        front_valid;
  logic        front_ready;
  byte_entry_t front_ent;
  logic        head_valid;
  logic        head_ready;
  byte_entry_t head_ent;

  // Configuration registers; writes leave the decoding state alone
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: image_height <= cfg_wdata;
        default:          image_width  <= image_width;
      endcase
    end
  end

  // Accept and classify bytes
  nrle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream),
    .ent_valid (front_valid),
    .ent_ready (front_ready),
    .ent       (front_ent)
  );

  // Decouple byte intake from pixel expansion
  nrle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_ent),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_data   (head_ent)
  );

  // Expand nibbles into pixels and advance the raster position
  nrle_back u_back (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .head_valid   (head_valid),
    .head_ready   (head_ready),
    .head         (head_ent),
    .pixel        (pixel)
  );

endmodule

@@ hw/rtl/nrle_front.sv @@
// Front end: takes compressed bytes and tags the nibbles that open a run.
// Depends on nrle_pkg and nrle_byte_if.
module nrle_front (
  input  logic                 clk,
  input  logic                 rst,
  nrle_byte_if.sink            stream,
  output logic                 ent_valid,
  input  logic                 ent_ready,
  output nrle_pkg::byte_entry_t ent
);
  import nrle_pkg::*;

  assign stream.ready = !ent_valid || ent_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      ent_valid <= 1'b1;
    end else if (ent_ready) begin
      ent_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      ent.data    <= stream.stream_byte;
      ent.hi_open <= is_run_code(stream.stream_byte[7:4]);
      ent.lo_open <= is_run_code(stream.stream_byte[3:0]);
    end
  end

endmodule

@@ hw/rtl/nrle_queue.sv @@
// Small register queue between the front end and the pixel sequencer.
// Depends on nrle_pkg.
module nrle_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  nrle_pkg::byte_entry_t push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output nrle_pkg::byte_entry_t pop_data
);
  import nrle_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  byte_entry_t    slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ hw/rtl/nrle_back.sv @@
// Pixel sequencer: walks the two nibbles of each queued byte, expands runs
// one pixel per cycle while a byte is queued and the output register is free,
// and tracks the raster position. Depends on nrle_pkg and nrle_pixel_if.
module nrle_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            image_width,
  input  logic [7:0]            image_height,
  input  logic                  head_valid,
  output logic                  head_ready,
  input  nrle_pkg::byte_entry_t head,
  nrle_pixel_if.source          pixel
);
  import nrle_pkg::*;

  logic       nib_sel, nib_sel_next;
  logic       running, running_next;
  logic [4:0] run_left, run_left_next;
  logic       awaiting, awaiting_next;
  logic [3:0] run_gray, run_gray_next;
  logic [7:0] column, column_next;
  logic [7:0] row, row_next;

  logic       out_valid;
  pixel_t     out_data;

  logic [3:0] code;
  logic       code_open;
  logic       out_free;
  logic       step;
  logic       complete;
  logic       emit;
  logic       nibble_end;
  logic [3:0] gray;
  logic [8:0] col_inc;
  logic       wrap;
  logic [7:0] row_inc;
  logic       done;
  pixel_t     pix;

  assign code      = nib_sel ? head.data[3:0] : head.data[7:4];
  assign code_open = nib_sel ? head.lo_open : head.hi_open;
  assign out_free  = !out_valid || pixel.ready;
  assign step      = head_valid && out_free;
  assign complete  = (row >= image_height);

  assign col_inc = {1'b0, column} + 9'd1;
  assign wrap    = (col_inc >= {1'b0, image_width});
  assign row_inc = row + 8'd1;
  assign done    = wrap && (row_inc >= image_height);

  always_comb begin
    nib_sel_next  = nib_sel;
    running_next  = running;
    run_left_next = run_left;
    awaiting_next = awaiting;
    run_gray_next = run_gray;
    column_next   = column;
    row_next      = row;
    emit          = 1'b0;
    nibble_end    = 1'b0;
    head_ready    = 1'b0;
    gray          = code;

    if (step) begin
      priority if (complete) begin
        // drop everything until the height is raised or reset
        head_ready   = 1'b1;
        nib_sel_next = 1'b0;
        running_next = 1'b0;
      end else if (running) begin
        emit          = 1'b1;
        gray          = run_gray;
        run_left_next = run_left - 5'd1;
        if (run_left == 5'd1) begin
          running_next = 1'b0;
          nibble_end   = 1'b1;
        end
      end else if (awaiting) begin
        emit          = 1'b1;
        gray          = run_gray;
        awaiting_next = 1'b0;
        if (code == 4'd0) begin
          nibble_end = 1'b1;
        end else begin
          running_next  = 1'b1;
          run_left_next = {1'b0, code};
        end
      end else if (code_open) begin
        awaiting_next = 1'b1;
        run_gray_next = code;
        nibble_end    = 1'b1;
      end else begin
        emit       = 1'b1;
        nibble_end = 1'b1;
      end

      if (nibble_end && !complete) begin
        if (nib_sel) begin
          head_ready   = 1'b1;
          nib_sel_next = 1'b0;
        end else begin
          nib_sel_next = 1'b1;
        end
      end
    end

    if (emit) begin
      column_next = wrap ? '0 : col_inc[7:0];
      row_next    = wrap ? row_inc : row;
    end
  end

  // a pixel closes its byte when it ends the low nibble, when the low nibble
  // will only open a run, or when it finishes the image
  always_comb begin
    pix.color = gray_to_color(gray);
    pix.x     = column;
    pix.y     = row;
    pix.done  = done;
    pix.last  = done || (nibble_end && (nib_sel || head.lo_open));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nib_sel   <= 1'b0;
      running   <= 1'b0;
      run_left  <= '0;
      awaiting  <= 1'b0;
      run_gray  <= '0;
      column    <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      nib_sel  <= nib_sel_next;
      running  <= running_next;
      run_left <= run_left_next;
      awaiting <= awaiting_next;
      run_gray <= run_gray_next;
      column   <= column_next;
      row      <= row_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pixel.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= pix;
    end
  end

  assign pixel.valid        = out_valid;
  assign pixel.pixel_color  = out_data.color;
  assign pixel.pixel_x      = out_data.x;
  assign pixel.pixel_y      = out_data.y;
  assign pixel.last_of_byte = out_data.last;
  assign pixel.image_done   = out_data.done;

endmodule
